### rtl/nbcd_pkg.sv
// Constants and nibble-level functions shared by the block cipher decrypt pipeline.
`default_nettype none

package nbcd_pkg;

    localparam int BLK_W     = 32;
    localparam int NIB_N     = BLK_W / 4;
    localparam int KEY_N     = 8;
    localparam int KEY_IDX_W = $clog2(KEY_N);

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [3:0]       t_nib;

    // Field polynomial x^4 + x^3 + 1
    localparam logic [4:0] GF_POLY = 5'h19;

    // First row of the circulant column mix
    localparam t_nib MIX_ROW [4] = '{4'he, 4'hb, 4'hd, 4'h9};

    // Substitution box
    localparam t_nib SBOX [16] = '{
        4'h8, 4'hc, 4'h1, 4'h0, 4'he, 4'h4, 4'hf, 4'h6,
        4'ha, 4'hb, 4'hd, 4'h3, 4'h5, 4'h7, 4'h9, 4'h2
    };

    // GF(16) multiply, shift-and-add over four bits
    function automatic t_nib gf_mul(input t_nib a_in, input t_nib b);
        logic [4:0] a;
        t_nib       p;
        a = {1'b0, a_in};
        p = '0;
        for (int k = 0; k < 4; k++) begin
            if (b[k]) begin
                p = p ^ a[3:0];
            end
            a = {a[3:0], 1'b0};
            if (a[4]) begin
                a = a ^ GF_POLY;
            end
        end
        return p;
    endfunction

    // Fixed nibble permutation
    function automatic t_blk permute(input t_blk s);
        t_blk t;
        t[3:0]   = s[19:16];
        t[7:4]   = s[3:0];
        t[11:8]  = s[23:20];
        t[15:12] = s[7:4];
        t[19:16] = s[27:24];
        t[23:20] = s[11:8];
        t[27:24] = s[31:28];
        t[31:28] = s[15:12];
        return t;
    endfunction

    // Circulant mix on both columns; nibble 2r+c is row r, column c
    function automatic t_blk mix(input t_blk s);
        t_blk           t;
        t_nib           acc;
        logic [1:0]     sel;
        for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < 4; i++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    sel = 2'(k - i);
                    acc = acc ^ gf_mul(MIX_ROW[sel], s[4*(2*k+c) +: 4]);
                end
                t[4*(2*i+c) +: 4] = acc;
            end
        end
        return t;
    endfunction

    // S-box on every nibble
    function automatic t_blk subst(input t_blk s);
        t_blk t;
        for (int n = 0; n < NIB_N; n++) begin
            t[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/nibble_block_cipher_decrypt.sv
// Top level: key registers, whitening plus first round, and six pipelined mixing rounds.
//
// channel   | role          | beat contents
// ----------+---------------+------------------------------------------
// s_axis    | block in      | tdata[31:0] cipher_block
// m_axis    | block out     | tdata[31:0] plain_block
// apb       | key registers | round_key_0..7 at 0x00, 0x04, .. 0x1c
//
// One block per cycle sustained while m_axis_tready stays high; each beat is registered in
// the first stage (whitening with round one), then in one stage per mixing round.
// Reset clears all stage valid bits and all round keys to zero.
// Each stage holds while the next one is full and stalled; empty stages are
// filled, so s_axis_tready stays high until every stage holds a block.
`default_nettype none

module nibble_block_cipher_decrypt
    import nbcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // block in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] cipher_block
    // block out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] plain_block
    // key registers
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RND_N = 6;

    // Index of the whitening key register
    localparam logic [KEY_IDX_W-1:0] KEY_WHITEN = '0;

    t_blk               r_key [KEY_N];
    logic [KEY_IDX_W-1:0] w_idx;
    logic               w_wr;

    logic               r_valid0;
    t_blk               r_data0;
    t_blk               n_data0;

    logic               w_vld [RND_N+1];
    t_blk               w_dat [RND_N+1];
    logic               w_rdy [RND_N+2];

    // Register port
    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = r_key[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_N; k++) begin
                r_key[k] <= '0;
            end
        end else if (w_wr) begin
            r_key[w_idx] <= pwdata;
        end
    end

    // Whitening and first round, which has no column mix
    assign n_data0 = subst(permute(s_axis_tdata ^ r_key[KEY_WHITEN])) ^ r_key[1];

    assign w_rdy[0]      = !r_valid0 || w_rdy[1];
    assign s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (w_rdy[0]) begin
            r_valid0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && s_axis_tvalid) begin
            r_data0 <= n_data0;
        end
    end

    assign w_vld[0] = r_valid0;
    assign w_dat[0] = r_data0;

    // Mixing rounds two through seven
    for (genvar g = 1; g <= RND_N; g++) begin : g_round
        nbcd_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g-1]),
            .o_ready (w_rdy[g]),
            .i_data  (w_dat[g-1]),
            .i_key   (r_key[g+1]),
            .o_valid (w_vld[g]),
            .o_data  (w_dat[g]),
            .i_ready (w_rdy[g+1])
        );
    end

    assign w_rdy[RND_N+1] = m_axis_tready;
    assign m_axis_tvalid  = w_vld[RND_N];
    assign m_axis_tdata   = w_dat[RND_N];

    // Checks
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !r_valid0)
        else $error("pipeline not empty after reset");

    a_drained_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && w_idx == KEY_WHITEN |=> r_key[KEY_WHITEN] == $past(pwdata))
        else $error("whitening key write lost");

    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid0 && !w_rdy[1] |=> r_valid0 && $stable(r_data0))
        else $error("first stage changed while stalled");

endmodule

`default_nettype wire

### rtl/nbcd_round.sv
// One mixing round of the decrypt pipeline: permute, mix, substitute, add key, register.
`default_nettype none

module nbcd_round
    import nbcd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_blk i_data,
    input  wire t_blk i_key,
    output logic      o_valid,
    output t_blk      o_data,
    input  wire logic i_ready
);

    logic r_valid;
    t_blk r_data;
    t_blk n_data;

    // Round function
    assign n_data = subst(mix(permute(i_data))) ^ i_key;

    // Stage takes a beat when empty or when its contents move on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### tb/nibble_block_cipher_decrypt_checker.sv
// Checker for the nibble block cipher decrypt unit: tracks the keys, predicts and compares.
`timescale 1ns / 1ps

module nibble_block_cipher_decrypt_checker
    import nbcd_pkg::*;
#(
    parameter int KEY_STRIDE  = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // block in
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [31:0] i_in_data,    // [31:0] cipher_block
    // block out
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_out_data,   // [31:0] plain_block
    // key registers
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [4:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic [31:0] i_prdata,
    input  wire logic        i_pready,
    output int               o_fail_cnt,
    output int               o_pending
);

    localparam int ROUNDS = 7;

    // Decrypt-side substitution and mix coefficients
    localparam logic [3:0] SUB_NIB [16] = '{
        4'h8, 4'hc, 4'h1, 4'h0, 4'he, 4'h4, 4'hf, 4'h6,
        4'ha, 4'hb, 4'hd, 4'h3, 4'h5, 4'h7, 4'h9, 4'h2
    };
    localparam logic [3:0] MIX_COEF [4] = '{4'he, 4'hb, 4'hd, 4'h9};
    // Source nibble for each destination nibble of the permutation
    localparam int PERM_FROM [8] = '{4, 0, 5, 1, 6, 2, 7, 3};

    typedef struct {
        t_blk cipher;
        t_blk plain;
    } t_due;

    t_blk key_reg [KEY_N] = '{default: '0};
    t_due plain_due [$];
    int   fail_cnt = 0;

    // GF(16) product, x^4 = x^3 + 1
    function automatic logic [3:0] gf16_times(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] prod;
        logic [3:0] shifted;
        prod    = '0;
        shifted = a;
        for (int k = 0; k < 4; k++) begin
            if (b[k]) begin
                prod = prod ^ shifted;
            end
            shifted = shifted[3] ? ((shifted << 1) ^ 4'h9) : (shifted << 1);
        end
        return prod;
    endfunction

    // Plain block for one cipher block under the current keys
    function automatic t_blk decrypt_block(input t_blk cipher);
        logic [3:0] cur [8];
        logic [3:0] nxt [8];
        logic [3:0] acc;
        t_blk       word;
        word = cipher ^ key_reg[0];
        for (int r = 0; r < ROUNDS; r++) begin
            for (int n = 0; n < 8; n++) begin
                cur[n] = word[4*PERM_FROM[n] +: 4];
            end
            // column mix skipped in the first round
            if (r != 0) begin
                for (int c = 0; c < 2; c++) begin
                    for (int i = 0; i < 4; i++) begin
                        acc = '0;
                        for (int k = 0; k < 4; k++) begin
                            acc = acc ^ gf16_times(MIX_COEF[(k - i) & 3], cur[2*k + c]);
                        end
                        nxt[2*i + c] = acc;
                    end
                end
                cur = nxt;
            end
            for (int n = 0; n < 8; n++) begin
                word[4*n +: 4] = SUB_NIB[cur[n]];
            end
            word = word ^ key_reg[r + 1];
        end
        return word;
    endfunction

    // Watch all three channels on the rising edge
    always @(posedge i_clk) begin
        t_due head;
        int   key_idx;
        if (i_rst_n) begin
            key_idx = i_paddr / KEY_STRIDE;
            if (i_psel && i_penable && i_pready && key_idx < KEY_N) begin
                if (i_pwrite) begin
                    key_reg[key_idx] <= i_pwdata;
                end else if (i_prdata !== key_reg[key_idx]) begin
                    $display("%0t: key %0d readback: expected %08h, actual %08h",
                             $time, key_idx, key_reg[key_idx], i_prdata);
                    fail_cnt++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                plain_due.push_back('{cipher: i_in_data, plain: decrypt_block(i_in_data)});
            end
            if (i_out_valid && i_out_ready) begin
                if (plain_due.size() == 0) begin
                    $display("%0t: output beat with none due: expected nothing, actual %08h",
                             $time, i_out_data);
                    fail_cnt++;
                end else begin
                    head = plain_due.pop_front();
                    if (i_out_data !== head.plain) begin
                        $display("%0t: plain_block for cipher %08h: expected %08h, actual %08h",
                                 $time, head.cipher, head.plain, i_out_data);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending  <= plain_due.size();
        o_fail_cnt <= fail_cnt;
    end

endmodule

### tb/nibble_block_cipher_decrypt_tb.sv
// Top of the testbench: clock, reset, key programming, block stimulus and verdict.
`timescale 1ns / 1ps

module nibble_block_cipher_decrypt_tb
    import nbcd_pkg::*;
();

    localparam int KEY_STRIDE       = 4;
    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int DRAIN_CYCLES     = 12;
    localparam int KEY_PHASES       = 5;
    localparam int RANDOM_PER_PHASE = 160;
    localparam int TIMEOUT_NS       = 3_000_000;

    // Corner blocks run under the reset keys
    localparam t_blk EDGE_BLOCKS [14] = '{
        32'h0000_0000, 32'hffff_ffff, 32'h0123_4567, 32'h89ab_cdef,
        32'h7654_3210, 32'hfedc_ba98, 32'h0000_000f, 32'hf000_0000,
        32'h0000_0001, 32'h8000_0000, 32'h5a5a_5a5a, 32'ha5a5_a5a5,
        32'h0f0f_0f0f, 32'hf0f0_f0f0
    };

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] cipher_block
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] plain_block
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_cnt;
    int pending;
    int burst_left;

    nibble_block_cipher_decrypt u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    nibble_block_cipher_decrypt_checker #(
        .KEY_STRIDE (KEY_STRIDE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Random block, sometimes built from all-zero and all-one nibbles
    function automatic t_blk rand_block();
        t_blk blk;
        blk = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            for (int n = 0; n < NIB_N; n++) begin
                case ($urandom_range(0, 2))
                    0:       blk[4*n +: 4] = 4'h0;
                    1:       blk[4*n +: 4] = 4'hf;
                    default: ;
                endcase
            end
        end
        return blk;
    endfunction

    // One block beat; bursts of random length separated by random gaps
    task automatic send_block(input t_blk blk);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // One APB access; psel stays up for a following access
    task automatic apb_xfer(input logic is_write, input int idx, input t_blk value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 5'(idx * KEY_STRIDE);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // Write a key set for this phase, then read every key back
    task automatic load_keys(input int phase);
        t_blk key_set [KEY_N];
        for (int k = 0; k < KEY_N; k++) begin
            case (phase)
                1:       key_set[k] = '1;
                2:       key_set[k] = k[0] ? '1 : '0;
                default: key_set[k] = $urandom;
            endcase
        end
        for (int k = 0; k < KEY_N; k++) begin
            apb_xfer(1'b1, k, key_set[k]);
        end
        for (int k = 0; k < KEY_N; k++) begin
            apb_xfer(1'b0, k, '0);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop sending and let the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Receiver stall pattern, switching mode every stretch
    initial begin
        t_rx_mode mode;
        int       stretch;
        m_axis_tready = 1'b0;
        mode          = RX_OPEN;
        stretch       = 0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                mode    = t_rx_mode'($urandom_range(0, 3));
                stretch = $urandom_range(16, 160);
            end
            stretch--;
            case (mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (stretch % 3 == 0);
            endcase
        end
    end

    // Stimulus and verdict
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        burst_left    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed blocks under the reset keys
        foreach (EDGE_BLOCKS[i]) begin
            send_block(EDGE_BLOCKS[i]);
        end
        drain();

        // random blocks, one key set per phase
        for (int p = 1; p <= KEY_PHASES; p++) begin
            load_keys(p);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_block(rand_block());
            end
            drain();
        end

        if (fail_cnt == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### nibble_block_cipher_decrypt.f
rtl/nbcd_pkg.sv
rtl/nbcd_round.sv
rtl/nibble_block_cipher_decrypt.sv
tb/nibble_block_cipher_decrypt_checker.sv
tb/nibble_block_cipher_decrypt_tb.sv
